>>> sv/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mtach_pkg.sv
package mtach_pkg;

    localparam int CHANNELS = 3;
    localparam int CH_W = 2;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KIND_REF  = 2'd0,
        KIND_PULSE = 2'd1,
        KIND_CALC = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_FREQ    = 3'd0,
        REG_SPOKES_A = 3'd1,
        REG_SPOKES_C = 3'd3,
        REG_MAX_A   = 3'd4,
        REG_MAX_C   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] channel;
    } req_t;

    typedef struct packed {
        logic [1:0]  rpm_channel;
        logic [15:0] rpm_value;
    } rsp_t;

endpackage

>>> sv/mtach_if.sv
interface mtach_req_if
    import mtach_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] channel;
    modport source (output valid, kind, channel, input ready);
    modport sink (input valid, kind, channel, output ready);
endinterface

interface mtach_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  rpm_channel;
    logic [15:0] rpm_value;
    modport source (output valid, rpm_channel, rpm_value, input ready);
    modport sink (input valid, rpm_channel, rpm_value, output ready);
endinterface

interface mtach_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/mtach_front.sv
// Request queue between the port and the execution engine.
module mtach_front
    import mtach_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_req,
    output logic  q_valid,
    input  logic  q_pop,
    output req_t  q_req
);
    req_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end
endmodule

>>> sv/mtach_div.sv
// Restoring divider, 64-bit numerator over 40-bit divisor, one bit per cycle.
module mtach_div
    import mtach_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [39:0] den,
    output logic        busy,
    output logic [15:0] quo,
    output logic [39:0] rem
);
    logic [63:0] q_reg;
    logic [40:0] r_reg;
    logic [39:0] d_reg;
    logic [6:0]  n_reg;
    logic [40:0] sh;
    logic [41:0] diff;

    assign busy = (n_reg != 7'd0);
    assign sh   = {r_reg[39:0], q_reg[63]};
    assign diff = {1'b0, sh} - {2'b0, d_reg};
    // saturate when any quotient bit above bit 15 is set
    assign quo  = (|q_reg[63:16]) ? 16'hFFFF : q_reg[15:0];
    assign rem  = r_reg[39:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= 7'd0;
        end
        else if (start)
        begin
            n_reg <= 7'd64;
        end
        else if (busy)
        begin
            n_reg <= n_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (!diff[41])
            begin
                r_reg <= diff[40:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

>>> sv/mtach_back.sv
// Execution engine: channel state, lockout check, speed update, combinational result output.
module mtach_back
    import mtach_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        q_valid,
    input  req_t        q_req,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_rsp
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_CALC, S_DSTART, S_DWAIT, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE, MODE_RATE, MODE_BOUND, MODE_PULSE
    } mode_t;

    state_t      state_reg;
    logic [23:0] freq_reg;
    logic [7:0]  spk_reg [CHANNELS];
    logic [15:0] max_reg [CHANNELS];
    logic [31:0] pc_reg  [CHANNELS];
    logic [31:0] pt_reg  [CHANNELS];
    logic [31:0] ps_reg  [CHANNELS];
    logic [31:0] rp_reg  [CHANNELS];
    logic [31:0] rs_reg  [CHANNELS];
    logic [15:0] spd_reg [CHANNELS];
    req_t        cur_reg;
    logic [1:0]  ci_reg;
    logic [47:0] prod_reg;
    logic [63:0] lhs_reg;
    logic [29:0] rhs_reg;
    logic [63:0] num_reg;
    logic [39:0] den_reg;
    mode_t       mode_reg;
    rsp_t        rsp_reg;

    logic        div_start, div_busy;
    logic [15:0] div_quo;
    logic [39:0] div_rem;

    function automatic logic [29:0] rhs_calc(input logic [23:0] f);
        rhs_calc = 30'(f * 30'd60);
    endfunction

    mtach_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_reg), .den(den_reg),
        .busy(div_busy), .quo(div_quo), .rem(div_rem)
    );

    assign div_start = (state_reg == S_DSTART);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = (state_reg == S_EMIT);
    assign out_rsp   = rsp_reg;

    logic [1:0]  pch;
    logic [31:0] pt_inc, ps_add;
    logic [32:0] ps_wide;

    assign pch     = cur_reg.channel;
    assign pt_inc  = (pt_reg[pch] == 32'hFFFF_FFFF) ? pt_reg[pch] : pt_reg[pch] + 32'd1;
    assign ps_wide = {1'b0, ps_reg[pch]} + {1'b0, pc_reg[pch]};
    assign ps_add  = ps_wide[32] ? 32'hFFFF_FFFF : ps_wide[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            freq_reg  <= 24'd100000;
            for (int i = 0; i < CHANNELS; i++)
            begin
                spk_reg[i] <= 8'd1;
                max_reg[i] <= 16'hFFFF;
                pc_reg[i]  <= '0;
                pt_reg[i]  <= '0;
                ps_reg[i]  <= '0;
                rp_reg[i]  <= '0;
                rs_reg[i]  <= '0;
                spd_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FREQ)
                begin
                    freq_reg <= cfg_data;
                end
                else if (cfg_index >= REG_SPOKES_A && cfg_index <= REG_SPOKES_C)
                begin
                    spk_reg[2'(cfg_index - REG_SPOKES_A)] <= cfg_data[7:0];
                end
                else if (cfg_index >= REG_MAX_A && cfg_index <= REG_MAX_C)
                begin
                    max_reg[2'(cfg_index - REG_MAX_A)] <= cfg_data[15:0];
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_req;
                        ci_reg  <= 2'd0;
                        case (q_req.kind)
                            KIND_REF:
                            begin
                                for (int i = 0; i < CHANNELS; i++)
                                begin
                                    if (pc_reg[i] != 32'hFFFF_FFFF)
                                    begin
                                        pc_reg[i] <= pc_reg[i] + 32'd1;
                                    end
                                end
                                state_reg <= S_EMIT;
                            end
                            KIND_PULSE:
                            begin
                                state_reg <= (q_req.channel < 2'(CHANNELS)) ? S_MUL1 : S_EMIT;
                            end
                            KIND_CALC: state_reg <= S_CALC;
                            default: state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_MUL1:
                begin
                    prod_reg  <= 48'(pc_reg[pch]) * 48'(spk_reg[pch]);
                    rhs_reg   <= 30'(freq_reg * 30'd60);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // lockout product, and the revolution test on the divider
                    lhs_reg   <= 64'(prod_reg[39:0] * max_reg[pch]);
                    num_reg   <= 64'(pt_inc);
                    den_reg   <= 40'(spk_reg[pch]);
                    mode_reg  <= MODE_PULSE;
                    state_reg <= S_DSTART;
                end
                S_CALC:
                begin
                    // set up one channel's division, or skip a channel with nothing to divide
                    if (rp_reg[ci_reg] != 0)
                    begin
                        mode_reg <= MODE_RATE;
                        num_reg  <= 64'(rhs_calc(freq_reg) * rp_reg[ci_reg]);
                        den_reg  <= 40'(rs_reg[ci_reg] * spk_reg[ci_reg]);
                        state_reg <= S_DSTART;
                    end
                    else if (pt_reg[ci_reg] != 0)
                    begin
                        mode_reg <= MODE_RATE;
                        num_reg  <= 64'(rhs_calc(freq_reg) * pt_reg[ci_reg]);
                        den_reg  <= 40'(ps_reg[ci_reg] * spk_reg[ci_reg]);
                        state_reg <= S_DSTART;
                    end
                    else if (pc_reg[ci_reg] != 0 && spk_reg[ci_reg] != 0)
                    begin
                        mode_reg <= MODE_BOUND;
                        num_reg  <= 64'(rhs_calc(freq_reg));
                        den_reg  <= 40'(pc_reg[ci_reg] * spk_reg[ci_reg]);
                        state_reg <= S_DSTART;
                    end
                    else
                    begin
                        pt_reg[ci_reg] <= '0;
                        rp_reg[ci_reg] <= '0;
                        if (ci_reg == 2'(CHANNELS - 1))
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ci_reg <= ci_reg + 2'd1;
                        end
                    end
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (!div_busy)
                    begin
                        if (mode_reg == MODE_PULSE)
                        begin
                            // pulse lockout decision
                            if (spk_reg[pch] != 0 && max_reg[pch] != 0 &&
                                lhs_reg >= 64'(rhs_reg))
                            begin
                                pt_reg[pch] <= pt_inc;
                                ps_reg[pch] <= ps_add;
                                if (div_rem == 40'd0)
                                begin
                                    rp_reg[pch] <= pt_inc;
                                    rs_reg[pch] <= ps_add;
                                end
                                pc_reg[pch] <= '0;
                            end
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            if (mode_reg == MODE_RATE)
                            begin
                                spd_reg[ci_reg] <= (num_reg == 0) ? 16'd0 :
                                                   (den_reg == 0) ? 16'hFFFF : div_quo;
                                ps_reg[ci_reg] <= '0;
                                rs_reg[ci_reg] <= '0;
                            end
                            else if (num_reg == 0)
                            begin
                                spd_reg[ci_reg] <= 16'd0;
                            end
                            else if (div_quo < spd_reg[ci_reg])
                            begin
                                spd_reg[ci_reg] <= div_quo;
                            end
                            pt_reg[ci_reg] <= '0;
                            rp_reg[ci_reg] <= '0;
                            if (ci_reg == 2'(CHANNELS - 1))
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                ci_reg    <= ci_reg + 2'd1;
                                state_reg <= S_CALC;
                            end
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        rsp_reg.rpm_channel = cur_reg.channel;
        rsp_reg.rpm_value   = (cur_reg.channel < 2'(CHANNELS)) ? spd_reg[cur_reg.channel] : 16'd0;
    end
endmodule

>>> sv/multichannel_tachometer_top.sv
// Three-channel period tachometer. Requests enter a two-entry queue; an engine
// takes one at a time and returns one result per request, carrying the addressed
// channel and its speed after the update. A reference tick or an unused kind is
// answered directly; a pulse on a valid channel first forms the lockout products,
// then runs a 64-step divide for the revolution test; a calculation tick runs the
// shared 64-step divider once per channel that has pulses or a running counter.
// A stalled result holds the engine until the result is taken.
// Configuration writes are accepted at any time and must only be issued idle.
`include "assert_macros.svh"
module multichannel_tachometer_top
    import mtach_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    mtach_req_if.sink   req,
    mtach_rsp_if.source rsp,
    mtach_cfg_if.sink   cfg
);
    req_t in_req, q_req;
    rsp_t out_rsp;
    logic q_valid, q_pop;

    assign in_req.kind    = req.kind;
    assign in_req.channel = req.channel;
    assign cfg.ready      = 1'b1;
    assign rsp.rpm_channel = out_rsp.rpm_channel;
    assign rsp.rpm_value   = out_rsp.rpm_value;

    // hold requests while the engine works
    mtach_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    // advance channel state and produce the result
    mtach_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg.valid), .cfg_index(cfg.index),
        .cfg_data(cfg.data), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(out_rsp)
    );

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
    `ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop, !rsp.valid, "pop during result")
    `ASSERT_IMPL(a_range, clk, rst_n, rsp.valid && rsp.rpm_channel == 2'd3,
        rsp.rpm_value == 16'd0, "bad channel speed")
endmodule
